// ----- hw/rtl/keyword_operator_lexer_assert.svh -----
// Assertion macros used by the lexer top level.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef KEYWORD_OPERATOR_LEXER_ASSERT_SVH
`define KEYWORD_OPERATOR_LEXER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define KLEX_ASSERT_IMPL(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define KLEX_ASSERT_NEXT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ----- hw/rtl/klex_pkg.sv -----
// Shared types and constants of the keyword/operator lexer.
// No dependencies; used by klex_front, klex_back and keyword_operator_lexer.
package klex_pkg;

	localparam int TEXT_DEPTH  = 32;
	localparam int QUEUE_DEPTH = 4;

	// Character class of the open token
	typedef enum logic [2:0] {
		CLS_IDLE,
		CLS_NUM,
		CLS_WORD,
		CLS_OP,
		CLS_STR,
		CLS_OTHER
	} class_t;

	// Latched command mode for typing '='
	typedef enum logic [1:0] {
		MODE_NONE,
		MODE_IF,
		MODE_LET
	} mode_t;

	// Front-end sequencer states
	typedef enum logic {
		FE_RUN,
		FE_EOL
	} fe_state_t;

	// Token kinds as they appear on the output
	typedef enum logic [4:0] {
		KIND_NUM     = 5'd0,
		KIND_STR     = 5'd1,
		KIND_VAR     = 5'd2,
		KIND_IF      = 5'd3,
		KIND_THEN    = 5'd4,
		KIND_LET     = 5'd5,
		KIND_GOTO    = 5'd6,
		KIND_LIST    = 5'd7,
		KIND_RUN     = 5'd8,
		KIND_END     = 5'd9,
		KIND_PRINT   = 5'd10,
		KIND_INPUT   = 5'd11,
		KIND_MUL     = 5'd12,
		KIND_DIV     = 5'd13,
		KIND_ADD     = 5'd14,
		KIND_SUB     = 5'd15,
		KIND_COMMA   = 5'd16,
		KIND_NE      = 5'd17,
		KIND_LT      = 5'd18,
		KIND_GT      = 5'd19,
		KIND_LE      = 5'd20,
		KIND_GE      = 5'd21,
		KIND_LPAREN  = 5'd22,
		KIND_RPAREN  = 5'd23,
		KIND_EQ      = 5'd24,
		KIND_ASSIGN  = 5'd25,
		KIND_UNTYPED = 5'd26
	} kind_t;

	// Precedence levels
	localparam logic [2:0] PREC_NONE    = 3'd0;
	localparam logic [2:0] PREC_MULDIV  = 3'd1;
	localparam logic [2:0] PREC_ADDSUB  = 3'd2;
	localparam logic [2:0] PREC_COMPARE = 3'd3;
	localparam logic [2:0] PREC_ASSIGN  = 3'd4;
	localparam logic [2:0] PREC_KEYWORD = 3'd6;

	// Token descriptor handed from front to back (length travels beside it)
	typedef struct packed {
		kind_t      kind;
		logic [2:0] prec;
		logic       ovf;       // text was cut at the buffer depth
		logic       empty;     // empty string, no stored text
		logic       last_run;  // final token caused by its input byte
		logic       bank;      // text buffer bank holding the bytes
	} desc_t;

	// Per-beat output attributes
	typedef struct packed {
		kind_t      kind;
		logic [2:0] prec;
		logic       bvalid;
		logic       last_tok;
		logic       trunc;
		logic       last_run;
	} beat_meta_t;

endpackage

// ----- hw/rtl/klex_queue.sv -----
// Small descriptor FIFO between the lexer front and back.
// Generic width and depth; no package dependencies.
module klex_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] store_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = store_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ----- hw/rtl/klex_front.sv -----
// Lexer front: classifies input bytes, tracks the open token, fills the
// text buffer and types each closed token. Depends on klex_pkg.
module klex_front #(
	parameter int TEXT_DEPTH = klex_pkg::TEXT_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// byte input
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [7:0]                      in_char,
	input  logic                            in_eol,
	// descriptor queue
	output logic                            push,
	output klex_pkg::desc_t                 push_desc,
	output logic [$clog2(TEXT_DEPTH+1)-1:0] push_len,
	input  logic                            q_full,
	// text buffer write port
	output logic                            wr_en,
	output logic                            wr_bank,
	output logic [$clog2(TEXT_DEPTH)-1:0]   wr_idx,
	output logic [7:0]                      wr_data,
	// bank release from the back
	input  logic                            rel_valid,
	input  logic                            rel_bank
);

	localparam int LEN_W      = $clog2(TEXT_DEPTH + 1);
	localparam int IDX_W      = $clog2(TEXT_DEPTH);
	localparam int KW_LEN     = 33;
	localparam int KW_COUNT   = 9;
	localparam int PREFIX_LEN = 5;
	localparam int PRE_IDX_W  = $clog2(PREFIX_LEN);

	localparam logic [8*KW_LEN-1:0] KW_TEXT = "IFTHENLETGOTOPRINTENDRUNLISTINPUT";

	// Keywords padded to the prefix length, in priority order
	localparam logic [8*PREFIX_LEN-1:0] KW_NAME [KW_COUNT] = '{
		"IF   ", "THEN ", "LET  ", "GOTO ", "LIST ", "RUN  ", "END  ", "PRINT", "INPUT"
	};
	localparam int KW_SIZE [KW_COUNT] = '{2, 4, 3, 4, 4, 3, 3, 5, 5};
	localparam klex_pkg::kind_t KW_KIND [KW_COUNT] = '{
		klex_pkg::KIND_IF, klex_pkg::KIND_THEN, klex_pkg::KIND_LET,
		klex_pkg::KIND_GOTO, klex_pkg::KIND_LIST, klex_pkg::KIND_RUN,
		klex_pkg::KIND_END, klex_pkg::KIND_PRINT, klex_pkg::KIND_INPUT
	};

	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_EQUAL  = 8'h3D;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_QUOTE  = 8'h22;

	function automatic logic is_upper(input logic [7:0] c);
		return c inside {[8'h41:8'h5A]};
	endfunction

	function automatic klex_pkg::class_t byte_class(input logic [7:0] c);
		klex_pkg::class_t cls;
		if (c inside {[8'h30:8'h39]}) begin
			cls = klex_pkg::CLS_NUM;
		end else if (c inside {[8'h41:8'h5A], [8'h61:8'h7A]}) begin
			cls = klex_pkg::CLS_WORD;
		end else if (c inside {CH_STAR, CH_SLASH, CH_PLUS, CH_MINUS, CH_LT, CH_GT,
				CH_EQUAL, CH_COMMA, CH_LPAREN, CH_RPAREN}) begin
			cls = klex_pkg::CLS_OP;
		end else if (c == CH_QUOTE) begin
			cls = klex_pkg::CLS_STR;
		end else begin
			cls = klex_pkg::CLS_OTHER;
		end
		return cls;
	endfunction

	// One bit per place in the keyword string that holds this letter
	function automatic logic [KW_LEN-1:0] position_bits(input logic [7:0] c);
		logic [KW_LEN-1:0] m;
		m = '0;
		for (int p = 0; p < KW_LEN; p++) begin
			if (KW_TEXT[8*(KW_LEN-1-p) +: 8] == c) begin
				m[p] = 1'b1;
			end
		end
		return m;
	endfunction

	klex_pkg::fe_state_t st_q, st_d;
	klex_pkg::class_t    cls_q, cls_d;
	klex_pkg::mode_t     mode_q, mode_d;
	logic [LEN_W-1:0]    len_q, len_d;
	logic [KW_LEN-1:0]   mask_q, mask_d;
	logic                ovf_q, ovf_d;
	logic                wb_q, wb_d;
	logic [1:0]          busy_q, busy_d;
	logic [7:0]          pre_q [PREFIX_LEN];
	logic [7:0]          pre_d [PREFIX_LEN];

	// close of the open token, from the registered state
	logic                cl_emit;
	logic                cl_empty;
	klex_pkg::kind_t     cl_kind;
	logic [2:0]          cl_prec;
	klex_pkg::mode_t     cl_mode;
	logic                kw_hit;
	klex_pkg::kind_t     kw_kind;
	logic [7:0]          op_b;

	// per-byte decisions
	klex_pkg::class_t    in_cls;
	klex_pkg::class_t    cls_after;
	logic                d_close;
	logic                d_append;
	logic                d_start;
	logic                d_extend;
	logic                push_now;
	logic                toggle;
	logic                app_bank;
	logic                go_eol;
	logic                new_emit;
	logic [LEN_W-1:0]    len_base;
	logic                acc;

	// Keyword prefix search, lowest entry wins
	always_comb begin
		logic match;
		kw_hit  = 1'b0;
		kw_kind = klex_pkg::KIND_UNTYPED;
		for (int k = KW_COUNT - 1; k >= 0; k--) begin
			match = (int'(len_q) >= KW_SIZE[k]);
			for (int j = 0; j < PREFIX_LEN; j++) begin
				if (j < KW_SIZE[k] && pre_q[j] != KW_NAME[k][8*(PREFIX_LEN-1-j) +: 8]) begin
					match = 1'b0;
				end
			end
			if (match) begin
				kw_hit  = 1'b1;
				kw_kind = KW_KIND[k];
			end
		end
	end

	// Typing of the token being closed
	always_comb begin
		cl_emit  = 1'b0;
		cl_empty = 1'b0;
		cl_kind  = klex_pkg::KIND_UNTYPED;
		cl_prec  = klex_pkg::PREC_NONE;
		cl_mode  = mode_q;
		op_b     = (len_q > LEN_W'(1)) ? pre_q[1] : 8'h00;
		case (cls_q)
			klex_pkg::CLS_NUM: begin
				cl_emit = 1'b1;
				cl_kind = klex_pkg::KIND_NUM;
			end
			klex_pkg::CLS_WORD: begin
				if (mask_q != '0 && kw_hit) begin
					cl_emit = 1'b1;
					cl_kind = kw_kind;
					cl_prec = klex_pkg::PREC_KEYWORD;
					if (kw_kind == klex_pkg::KIND_IF) begin
						cl_mode = klex_pkg::MODE_IF;
					end else if (kw_kind == klex_pkg::KIND_LET) begin
						cl_mode = klex_pkg::MODE_LET;
					end
				end else if (len_q == LEN_W'(1) && is_upper(pre_q[0])) begin
					cl_emit = 1'b1;
					cl_kind = klex_pkg::KIND_VAR;
				end
			end
			klex_pkg::CLS_OP: begin
				cl_emit = (len_q != '0);
				if (pre_q[0] == CH_STAR) begin
					cl_kind = klex_pkg::KIND_MUL;
					cl_prec = klex_pkg::PREC_MULDIV;
				end else if (pre_q[0] == CH_SLASH) begin
					cl_kind = klex_pkg::KIND_DIV;
					cl_prec = klex_pkg::PREC_MULDIV;
				end else if (pre_q[0] == CH_PLUS) begin
					cl_kind = klex_pkg::KIND_ADD;
					cl_prec = klex_pkg::PREC_ADDSUB;
				end else if (pre_q[0] == CH_COMMA) begin
					cl_kind = klex_pkg::KIND_COMMA;
					cl_prec = klex_pkg::PREC_KEYWORD;
				end else if (pre_q[0] == CH_MINUS) begin
					cl_kind = klex_pkg::KIND_SUB;
					cl_prec = klex_pkg::PREC_ADDSUB;
				end else if (pre_q[0] == CH_LT && op_b == CH_GT) begin
					cl_kind = klex_pkg::KIND_NE;
					cl_prec = klex_pkg::PREC_COMPARE;
				end else if (pre_q[0] == CH_LT && op_b == CH_EQUAL) begin
					cl_kind = klex_pkg::KIND_LE;
					cl_prec = klex_pkg::PREC_COMPARE;
				end else if (pre_q[0] == CH_GT && op_b == CH_EQUAL) begin
					cl_kind = klex_pkg::KIND_GE;
					cl_prec = klex_pkg::PREC_COMPARE;
				end else if (pre_q[0] == CH_LT) begin
					cl_kind = klex_pkg::KIND_LT;
					cl_prec = klex_pkg::PREC_COMPARE;
				end else if (pre_q[0] == CH_GT) begin
					cl_kind = klex_pkg::KIND_GT;
					cl_prec = klex_pkg::PREC_COMPARE;
				end else if (pre_q[0] == CH_LPAREN) begin
					cl_kind = klex_pkg::KIND_LPAREN;
				end else if (pre_q[0] == CH_RPAREN) begin
					cl_kind = klex_pkg::KIND_RPAREN;
				end else if (mode_q == klex_pkg::MODE_IF) begin
					cl_kind = klex_pkg::KIND_EQ;
					cl_prec = klex_pkg::PREC_COMPARE;
					cl_mode = klex_pkg::MODE_NONE;
				end else if (mode_q == klex_pkg::MODE_LET) begin
					cl_kind = klex_pkg::KIND_ASSIGN;
					cl_prec = klex_pkg::PREC_ASSIGN;
					cl_mode = klex_pkg::MODE_NONE;
				end
			end
			klex_pkg::CLS_STR: begin
				cl_emit  = 1'b1;
				cl_kind  = klex_pkg::KIND_STR;
				cl_empty = (len_q == '0);
			end
			default: begin
			end
		endcase
	end

	// What the incoming byte does to the open token
	always_comb begin
		in_cls    = byte_class(in_char);
		d_close   = 1'b0;
		d_append  = 1'b0;
		d_start   = 1'b0;
		d_extend  = 1'b0;
		cls_after = klex_pkg::CLS_IDLE;
		if (cls_q == klex_pkg::CLS_STR) begin
			if (in_char == CH_QUOTE) begin
				d_close = 1'b1;
			end else begin
				d_append  = 1'b1;
				cls_after = klex_pkg::CLS_STR;
			end
		end else if (cls_q != klex_pkg::CLS_IDLE && in_cls == cls_q) begin
			d_extend  = 1'b1;
			d_append  = 1'b1;
			cls_after = cls_q;
		end else begin
			d_close = (cls_q != klex_pkg::CLS_IDLE);
			if (in_cls inside {klex_pkg::CLS_NUM, klex_pkg::CLS_WORD, klex_pkg::CLS_OP}) begin
				d_start   = 1'b1;
				d_append  = 1'b1;
				cls_after = in_cls;
			end else if (in_cls == klex_pkg::CLS_STR) begin
				d_start   = 1'b1;
				cls_after = klex_pkg::CLS_STR;
			end
		end
		push_now = d_close && cl_emit;
		toggle   = push_now && !cl_empty;
		app_bank = wb_q ^ toggle;
		len_base = d_close ? '0 : len_q;
		go_eol   = in_eol && (cls_after != klex_pkg::CLS_IDLE);
		// a token opened by this byte and closed by end of line: does it emit
		new_emit = (in_cls inside {klex_pkg::CLS_NUM, klex_pkg::CLS_OP, klex_pkg::CLS_STR}) ||
			(in_cls == klex_pkg::CLS_WORD && is_upper(in_char));
	end

	// Next state and outputs
	always_comb begin
		st_d      = st_q;
		cls_d     = cls_q;
		mode_d    = mode_q;
		len_d     = len_q;
		mask_d    = mask_q;
		ovf_d     = ovf_q;
		wb_d      = wb_q;
		busy_d    = busy_q;
		pre_d     = pre_q;
		in_ready  = 1'b0;
		acc       = 1'b0;
		push      = 1'b0;
		push_len  = len_q;
		push_desc = '{kind: cl_kind, prec: cl_prec, ovf: ovf_q, empty: cl_empty,
			last_run: 1'b1, bank: wb_q};
		wr_en     = 1'b0;
		wr_bank   = app_bank;
		wr_idx    = len_base[IDX_W-1:0];
		wr_data   = in_char;

		if (rel_valid) begin
			busy_d[rel_bank] = 1'b0;
		end

		case (st_q)
			klex_pkg::FE_RUN: begin
				in_ready = !(push_now && q_full) && !(d_append && busy_q[app_bank]);
				acc      = in_valid && in_ready;
				if (acc) begin
					push               = push_now;
					push_desc.last_run = !(go_eol && new_emit);
					if (d_close) begin
						mode_d = cl_mode;
						len_d  = '0;
						ovf_d  = 1'b0;
						mask_d = '1;
					end
					if (toggle) begin
						busy_d[wb_q] = 1'b1;
						wb_d         = ~wb_q;
					end
					cls_d = cls_after;
					if (d_start && in_cls == klex_pkg::CLS_WORD) begin
						mask_d = position_bits(in_char);
					end
					if (d_extend && cls_q == klex_pkg::CLS_WORD) begin
						mask_d = (mask_q << 1) & position_bits(in_char);
					end
					if (d_append) begin
						if (len_base < TEXT_DEPTH) begin
							wr_en = 1'b1;
							len_d = len_base + LEN_W'(1);
							if (len_base < PREFIX_LEN) begin
								pre_d[len_base[PRE_IDX_W-1:0]] = in_char;
							end
						end else begin
							ovf_d = 1'b1;
						end
					end
					if (go_eol) begin
						st_d = klex_pkg::FE_EOL;
					end
				end
			end
			klex_pkg::FE_EOL: begin
				// end of line closes the token opened or extended by the last byte
				if (!(cl_emit && q_full)) begin
					push   = cl_emit;
					mode_d = cl_mode;
					if (cl_emit && !cl_empty) begin
						busy_d[wb_q] = 1'b1;
						wb_d         = ~wb_q;
					end
					cls_d  = klex_pkg::CLS_IDLE;
					len_d  = '0;
					ovf_d  = 1'b0;
					mask_d = '1;
					st_d   = klex_pkg::FE_RUN;
				end
			end
			default: begin
				st_d = klex_pkg::FE_RUN;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= klex_pkg::FE_RUN;
			cls_q  <= klex_pkg::CLS_IDLE;
			mode_q <= klex_pkg::MODE_NONE;
			len_q  <= '0;
			mask_q <= '1;
			ovf_q  <= 1'b0;
			wb_q   <= 1'b0;
			busy_q <= '0;
		end else begin
			st_q   <= st_d;
			cls_q  <= cls_d;
			mode_q <= mode_d;
			len_q  <= len_d;
			mask_q <= mask_d;
			ovf_q  <= ovf_d;
			wb_q   <= wb_d;
			busy_q <= busy_d;
		end
	end

	// Leading bytes of the token, for keyword and operator typing
	always_ff @(posedge clk) begin
		pre_q <= pre_d;
	end

endmodule

// ----- hw/rtl/klex_back.sv -----
// Lexer back: owns the two-bank text buffer and plays each queued token
// out one stored byte per beat. Depends on klex_pkg.
module klex_back #(
	parameter int TEXT_DEPTH = klex_pkg::TEXT_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// descriptor queue
	input  logic                            q_empty,
	input  klex_pkg::desc_t                 q_desc,
	input  logic [$clog2(TEXT_DEPTH+1)-1:0] q_len,
	output logic                            q_pop,
	// text buffer write port
	input  logic                            wr_en,
	input  logic                            wr_bank,
	input  logic [$clog2(TEXT_DEPTH)-1:0]   wr_idx,
	input  logic [7:0]                      wr_data,
	// bank release to the front
	output logic                            rel_valid,
	output logic                            rel_bank,
	// result beats
	output logic                            out_valid,
	input  logic                            out_ready,
	output klex_pkg::beat_meta_t            out_meta,
	output logic [7:0]                      out_byte
);

	localparam int LEN_W = $clog2(TEXT_DEPTH + 1);
	localparam int IDX_W = $clog2(TEXT_DEPTH);

	logic [7:0]           text_mem [2][TEXT_DEPTH];

	logic                 cur_valid_q;
	klex_pkg::desc_t      cur_desc_q;
	logic [LEN_W-1:0]     cur_len_q;
	logic [IDX_W-1:0]     idx_q;

	logic                 valid_s1;
	klex_pkg::beat_meta_t meta_s1;
	logic [7:0]           rd_data_s1;
	logic                 valid_s2;
	klex_pkg::beat_meta_t meta_s2;
	logic [7:0]           byte_s2;

	logic                 move_s1;
	logic                 issue;
	logic                 last_beat;
	klex_pkg::beat_meta_t issue_meta;

	// Read issue and stage advance
	always_comb begin
		q_pop     = !cur_valid_q && !q_empty;
		move_s1   = valid_s1 && (!valid_s2 || out_ready);
		issue     = cur_valid_q && (!valid_s1 || move_s1);
		last_beat = cur_desc_q.empty || ((LEN_W'(idx_q) + LEN_W'(1)) == cur_len_q);
		rel_valid = issue && last_beat && !cur_desc_q.empty;
		rel_bank  = cur_desc_q.bank;
		issue_meta = '{kind: cur_desc_q.kind, prec: cur_desc_q.prec,
			bvalid: !cur_desc_q.empty, last_tok: last_beat,
			trunc: last_beat && cur_desc_q.ovf,
			last_run: last_beat && cur_desc_q.last_run};
	end

	assign out_valid = valid_s2;
	assign out_meta  = meta_s2;
	assign out_byte  = byte_s2;

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
		end else begin
			if (q_pop) begin
				cur_valid_q <= 1'b1;
			end else if (issue && last_beat) begin
				cur_valid_q <= 1'b0;
			end
			if (issue) begin
				valid_s1 <= 1'b1;
			end else if (move_s1) begin
				valid_s1 <= 1'b0;
			end
			if (move_s1) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Token being played out
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_desc_q <= q_desc;
			cur_len_q  <= q_len;
			idx_q      <= '0;
		end else if (issue) begin
			idx_q <= idx_q + IDX_W'(1);
		end
	end

	// Text buffer write
	always_ff @(posedge clk) begin
		if (wr_en) begin
			text_mem[wr_bank][wr_idx] <= wr_data;
		end
	end

	// Text buffer read and output stages
	always_ff @(posedge clk) begin
		if (issue) begin
			rd_data_s1 <= text_mem[cur_desc_q.bank][idx_q];
			meta_s1    <= issue_meta;
		end
		if (move_s1) begin
			meta_s2 <= meta_s1;
			byte_s2 <= meta_s1.bvalid ? rd_data_s1 : 8'h00;
		end
	end

endmodule

// ----- hw/rtl/keyword_operator_lexer.sv -----
// Keyword/operator lexer, top level: front, descriptor queue and back.
// Depends on klex_pkg, klex_front, klex_queue, klex_back and the assert header.
//
// Takes one source byte per beat and returns each finished token one stored
// text byte per beat. A line's final byte that leaves a token open holds the
// input while end of line closes that token. The front stalls while the
// four-entry descriptor queue is full or while the text buffer bank it must
// write is still being played out. The back has one read port on a two-bank
// text buffer: it gives one result beat per cycle while the receiver is ready
// and a token is loaded, and loads each token from the queue before it plays
// out that token's bytes.
`include "keyword_operator_lexer_assert.svh"

module keyword_operator_lexer #(
	parameter int TEXT_DEPTH = klex_pkg::TEXT_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] text_char
	input  logic        s_tlast,   // end_of_line
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [2:0] precedence, [10:3] text_byte, [15:11] zero
	output logic [7:0]  m_tuser,   // [4:0] token_kind, [5] byte_valid,
	                               // [6] text_truncated, [7] last_of_run
	output logic        m_tlast    // last_of_token
);

	localparam int LEN_W  = $clog2(TEXT_DEPTH + 1);
	localparam int IDX_W  = $clog2(TEXT_DEPTH);
	localparam int DESC_W = $bits(klex_pkg::desc_t);
	localparam int Q_W    = DESC_W + LEN_W;

	logic                 q_push;
	klex_pkg::desc_t      push_desc;
	logic [LEN_W-1:0]     push_len;
	logic                 q_full;
	logic                 q_pop;
	logic                 q_empty;
	logic [Q_W-1:0]       q_head;
	logic                 wr_en;
	logic                 wr_bank;
	logic [IDX_W-1:0]     wr_idx;
	logic [7:0]           wr_data;
	logic                 rel_valid;
	logic                 rel_bank;
	klex_pkg::beat_meta_t out_meta;
	logic [7:0]           out_byte;
	logic                 empty_beat;

	klex_front #(
		.TEXT_DEPTH(TEXT_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_char  (s_tdata),
		.in_eol   (s_tlast),
		.push     (q_push),
		.push_desc(push_desc),
		.push_len (push_len),
		.q_full   (q_full),
		.wr_en    (wr_en),
		.wr_bank  (wr_bank),
		.wr_idx   (wr_idx),
		.wr_data  (wr_data),
		.rel_valid(rel_valid),
		.rel_bank (rel_bank)
	);

	klex_queue #(
		.WIDTH(Q_W),
		.DEPTH(klex_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data({push_desc, push_len}),
		.full     (q_full),
		.pop      (q_pop),
		.pop_data (q_head),
		.empty    (q_empty)
	);

	klex_back #(
		.TEXT_DEPTH(TEXT_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_desc   (klex_pkg::desc_t'(q_head[Q_W-1:LEN_W])),
		.q_len    (q_head[LEN_W-1:0]),
		.q_pop    (q_pop),
		.wr_en    (wr_en),
		.wr_bank  (wr_bank),
		.wr_idx   (wr_idx),
		.wr_data  (wr_data),
		.rel_valid(rel_valid),
		.rel_bank (rel_bank),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_meta (out_meta),
		.out_byte (out_byte)
	);

	// Pack result beats onto the stream
	assign m_tdata = {5'b0, out_byte, out_meta.prec};
	assign m_tuser = {out_meta.last_run, out_meta.trunc, out_meta.bvalid, out_meta.kind};
	assign m_tlast = out_meta.last_tok;

	// Empty-string beat on the output
	assign empty_beat = m_tvalid && !out_meta.bvalid;

	// Checks
	`KLEX_ASSERT_IMPL(a_queue_no_overflow, q_push, !q_full, "descriptor pushed into full queue")
	`KLEX_ASSERT_IMPL(a_queue_no_underflow, q_pop, !q_empty, "descriptor popped from empty queue")
	`KLEX_ASSERT_NEXT(a_single_load, q_pop, !q_pop, "second load while one is active")
	`KLEX_ASSERT_IMPL(a_bank_write_safe, rel_valid && wr_en, wr_bank != rel_bank, "bank clash")
	`KLEX_ASSERT_IMPL(a_empty_beat_last, empty_beat, m_tlast && out_byte == 8'd0, "bad empty beat")

endmodule

// ----- tb/sv/keyword_operator_lexer_test.sv -----
// Self-checking testbench for keyword_operator_lexer: stream of source bytes in,
// token text beats out, checked against an in-bench tokenizer model.
// Depends on klex_pkg and the keyword_operator_lexer RTL.
module keyword_operator_lexer_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam string KW_TEXT = "IFTHENLETGOTOPRINTENDRUNLISTINPUT";
	localparam string OP_SET  = "*/+-<>=,()";
	localparam logic [7:0] QUOTE = 8'h22;
	localparam int KW_AT [9]  = '{0, 2, 6, 9, 13, 18, 21, 24, 28};
	localparam int KW_LEN [9] = '{2, 4, 3, 4, 5, 3, 3, 4, 5};

	// One expected output beat
	typedef struct {
		klex_pkg::kind_t kind;
		logic [2:0]      prec;
		logic [7:0]      text;
		bit              bvalid;
		bit              last_tok;
		bit              trunc;
		bit              last_run;
	} token_beat_t;

	// Tokenizer model plus the queue of beats still owed by the block
	class lexer_scoreboard;
		token_beat_t beats_due[$];
		token_beat_t step_beats[$];
		int          errors;

		klex_pkg::class_t open_class;
		logic [7:0]       text_buf [klex_pkg::TEXT_DEPTH];
		int               text_len;
		logic [32:0]      kw_mask;
		klex_pkg::mode_t  mode;
		bit               cut;
		string            kw_names [9];
		klex_pkg::kind_t  kw_kinds [9];

		function new();
			errors     = 0;
			open_class = klex_pkg::CLS_IDLE;
			text_len   = 0;
			kw_mask    = '1;
			mode       = klex_pkg::MODE_NONE;
			cut        = 0;
			kw_names   = '{"IF", "THEN", "LET", "GOTO", "LIST", "RUN", "END", "PRINT", "INPUT"};
			kw_kinds   = '{klex_pkg::KIND_IF, klex_pkg::KIND_THEN, klex_pkg::KIND_LET,
			               klex_pkg::KIND_GOTO, klex_pkg::KIND_LIST, klex_pkg::KIND_RUN,
			               klex_pkg::KIND_END, klex_pkg::KIND_PRINT, klex_pkg::KIND_INPUT};
		endfunction

		// Positions of c inside the keyword string
		function logic [32:0] kw_positions(logic [7:0] c);
			logic [32:0] m;
			m = '0;
			for (int p = 0; p < 33; p++)
				if (KW_TEXT[p] == c) m[p] = 1'b1;
			return m;
		endfunction

		function klex_pkg::class_t char_class(logic [7:0] c);
			if (c >= "0" && c <= "9") return klex_pkg::CLS_NUM;
			if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) return klex_pkg::CLS_WORD;
			for (int k = 0; k < 10; k++)
				if (OP_SET[k] == c) return klex_pkg::CLS_OP;
			if (c == QUOTE) return klex_pkg::CLS_STR;
			return klex_pkg::CLS_OTHER;
		endfunction

		function void append(logic [7:0] c);
			if (text_len < klex_pkg::TEXT_DEPTH) begin
				text_buf[text_len] = c;
				text_len++;
			end else begin
				cut = 1;
			end
		endfunction

		function void emit_text(klex_pkg::kind_t k, logic [2:0] p);
			token_beat_t b;
			for (int i = 0; i < text_len; i++) begin
				b.kind     = k;
				b.prec     = p;
				b.text     = text_buf[i];
				b.bvalid   = 1;
				b.last_tok = (i == text_len - 1);
				b.trunc    = (i == text_len - 1) ? cut : 1'b0;
				b.last_run = 0;
				step_beats = {step_beats, b};
			end
		endfunction

		function bit has_prefix(string w);
			if (text_len < w.len()) return 0;
			for (int k = 0; k < w.len(); k++)
				if (text_buf[k] != w[k]) return 0;
			return 1;
		endfunction

		// Keyword if the run is a substring starting with a keyword, else maybe a variable
		function void close_word();
			if (kw_mask != '0) begin
				for (int k = 0; k < 9; k++) begin
					if (has_prefix(kw_names[k])) begin
						if (kw_kinds[k] == klex_pkg::KIND_IF) mode = klex_pkg::MODE_IF;
						if (kw_kinds[k] == klex_pkg::KIND_LET) mode = klex_pkg::MODE_LET;
						emit_text(kw_kinds[k], klex_pkg::PREC_KEYWORD);
						return;
					end
				end
			end
			if (text_len == 1 && text_buf[0] >= "A" && text_buf[0] <= "Z")
				emit_text(klex_pkg::KIND_VAR, klex_pkg::PREC_NONE);
		endfunction

		// Operator typed by its leading characters
		function void close_op();
			logic [7:0] a;
			logic [7:0] b;
			a = text_buf[0];
			b = (text_len > 1) ? text_buf[1] : 8'h00;
			if (a == "*") emit_text(klex_pkg::KIND_MUL, klex_pkg::PREC_MULDIV);
			else if (a == "/") emit_text(klex_pkg::KIND_DIV, klex_pkg::PREC_MULDIV);
			else if (a == "+") emit_text(klex_pkg::KIND_ADD, klex_pkg::PREC_ADDSUB);
			else if (a == ",") emit_text(klex_pkg::KIND_COMMA, klex_pkg::PREC_KEYWORD);
			else if (a == "-") emit_text(klex_pkg::KIND_SUB, klex_pkg::PREC_ADDSUB);
			else if (a == "<" && b == ">") emit_text(klex_pkg::KIND_NE, klex_pkg::PREC_COMPARE);
			else if (a == "<" && b == "=") emit_text(klex_pkg::KIND_LE, klex_pkg::PREC_COMPARE);
			else if (a == ">" && b == "=") emit_text(klex_pkg::KIND_GE, klex_pkg::PREC_COMPARE);
			else if (a == "<") emit_text(klex_pkg::KIND_LT, klex_pkg::PREC_COMPARE);
			else if (a == ">") emit_text(klex_pkg::KIND_GT, klex_pkg::PREC_COMPARE);
			else if (a == "(") emit_text(klex_pkg::KIND_LPAREN, klex_pkg::PREC_NONE);
			else if (a == ")") emit_text(klex_pkg::KIND_RPAREN, klex_pkg::PREC_NONE);
			else if (mode == klex_pkg::MODE_IF) begin
				mode = klex_pkg::MODE_NONE;
				emit_text(klex_pkg::KIND_EQ, klex_pkg::PREC_COMPARE);
			end else if (mode == klex_pkg::MODE_LET) begin
				mode = klex_pkg::MODE_NONE;
				emit_text(klex_pkg::KIND_ASSIGN, klex_pkg::PREC_ASSIGN);
			end else begin
				emit_text(klex_pkg::KIND_UNTYPED, klex_pkg::PREC_NONE);
			end
		endfunction

		function void close_token();
			token_beat_t b;
			case (open_class)
				klex_pkg::CLS_NUM:  emit_text(klex_pkg::KIND_NUM, klex_pkg::PREC_NONE);
				klex_pkg::CLS_WORD: close_word();
				klex_pkg::CLS_OP:   if (text_len > 0) close_op();
				klex_pkg::CLS_STR: begin
					if (text_len == 0) begin
						// empty string: one beat with no text
						b.kind     = klex_pkg::KIND_STR;
						b.prec     = klex_pkg::PREC_NONE;
						b.text     = 8'h00;
						b.bvalid   = 0;
						b.last_tok = 1;
						b.trunc    = 0;
						b.last_run = 0;
						step_beats = {step_beats, b};
					end else begin
						emit_text(klex_pkg::KIND_STR, klex_pkg::PREC_NONE);
					end
				end
				default: ;
			endcase
			open_class = klex_pkg::CLS_IDLE;
			text_len   = 0;
			cut        = 0;
			kw_mask    = '1;
		endfunction

		// Accepted input beat: work out the beats it causes
		function void note_byte(logic [7:0] c, logic eol);
			klex_pkg::class_t cls;
			step_beats.delete();
			if (open_class == klex_pkg::CLS_STR) begin
				if (c == QUOTE) close_token();
				else append(c);
			end else begin
				cls = char_class(c);
				if (open_class != klex_pkg::CLS_IDLE && open_class == cls) begin
					if (cls == klex_pkg::CLS_WORD) kw_mask = (kw_mask << 1) & kw_positions(c);
					append(c);
				end else begin
					if (open_class != klex_pkg::CLS_IDLE) close_token();
					if (cls == klex_pkg::CLS_NUM || cls == klex_pkg::CLS_WORD ||
							cls == klex_pkg::CLS_OP) begin
						open_class = cls;
						if (cls == klex_pkg::CLS_WORD) kw_mask = kw_positions(c);
						append(c);
					end else if (cls == klex_pkg::CLS_STR) begin
						open_class = klex_pkg::CLS_STR;
					end
				end
			end
			if (eol && open_class != klex_pkg::CLS_IDLE) close_token();
			if (step_beats.size() > 0) step_beats[$].last_run = 1;
			beats_due = {beats_due, step_beats};
		endfunction

		function void cmp(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		// Accepted output beat against the oldest one owed
		function void check_beat(logic [15:0] data, logic [7:0] user, logic last);
			token_beat_t b;
			if (beats_due.size() == 0) begin
				$error("output beat with no token pending: tdata %h tuser %h", data, user);
				errors++;
				return;
			end
			b = beats_due.pop_front();
			cmp("token_kind", b.kind, user[4:0]);
			cmp("precedence", b.prec, data[2:0]);
			cmp("text_byte", b.text, data[10:3]);
			cmp("tdata_pad", 0, data[15:11]);
			cmp("byte_valid", b.bvalid, user[5]);
			cmp("last_of_token", b.last_tok, last);
			cmp("text_truncated", b.trunc, user[6]);
			cmp("last_of_run", b.last_run, user[7]);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic [7:0]  m_tuser;
	logic        m_tlast;

	lexer_scoreboard sb = new();
	int accepted_inputs = 0;
	int burst_left = 0;

	keyword_operator_lexer u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // [7:0] text_char
		.s_tlast  (s_tlast),   // end_of_line
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),   // [2:0] precedence, [10:3] text_byte, [15:11] zero
		.m_tuser  (m_tuser),   // [4:0] token_kind, [5] byte_valid,
		                       // [6] text_truncated, [7] last_of_run
		.m_tlast  (m_tlast)    // last_of_token
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Monitor: input beats are noted before output beats are checked
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				sb.note_byte(s_tdata, s_tlast);
				accepted_inputs++;
			end
			if (m_tvalid && m_tready) sb.check_beat(m_tdata, m_tuser, m_tlast);
		end
	end

	// Sender: bursts of random length separated by random gaps
	task automatic send_item(logic [7:0] c, logic eol);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tdata  <= c;
		s_tlast  <= eol;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic send_line(logic [7:0] line[$]);
		foreach (line[i]) send_item(line[i], i == line.size() - 1);
	endtask

	task automatic send_str(string s);
		logic [7:0] q[$];
		for (int i = 0; i < s.len(); i++) q = {q, s[i]};
		send_line(q);
	endtask

	// One token's bytes, mostly well formed, some noise
	task automatic add_token(ref logic [7:0] line[$]);
		int pick;
		int n;
		int k;
		logic [7:0] ch;
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			n = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 5);
			repeat (n) line = {line, 8'(8'h30 + 8'($urandom_range(0, 9)))};
		end else if (pick < 35) begin
			// keyword, sometimes run on along the keyword string
			k = $urandom_range(0, 8);
			n = ($urandom_range(0, 9) < 7) ? KW_LEN[k] : $urandom_range(KW_LEN[k], 33 - KW_AT[k]);
			for (int i = 0; i < n; i++) line = {line, KW_TEXT[KW_AT[k] + i]};
		end else if (pick < 45) begin
			n = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 8);
			repeat (n) begin
				ch = $urandom_range(0, 1) ? 8'h41 : 8'h61;
				line = {line, 8'(ch + 8'($urandom_range(0, 25)))};
			end
		end else if (pick < 55) begin
			ch = ($urandom_range(0, 4) == 0) ? 8'h61 : 8'h41;
			line = {line, 8'(ch + 8'($urandom_range(0, 25)))};
		end else if (pick < 75) begin
			n = ($urandom_range(0, 9) < 6) ? 1 : $urandom_range(2, 3);
			repeat (n) line = {line, OP_SET[$urandom_range(0, 9)]};
		end else if (pick < 88) begin
			line = {line, QUOTE};
			n = ($urandom_range(0, 14) == 0) ? $urandom_range(31, 40) : $urandom_range(0, 6);
			repeat (n) begin
				ch = 8'($urandom_range(0, 255));
				if (ch == QUOTE) ch = 8'h23;
				line = {line, ch};
			end
			if ($urandom_range(0, 99) < 85) line = {line, QUOTE};
		end else begin
			line = {line, 8'($urandom_range(0, 255))};
		end
	endtask

	task automatic add_separator(ref logic [7:0] line[$]);
		case ($urandom_range(0, 5))
			0, 1, 2: line = {line, 8'h20};
			3:       line = {line, 8'h09};
			4:       line = {line, 8'($urandom_range(128, 255))};
			default: line = {line, 8'($urandom_range(0, 31))};
		endcase
	endtask

	task automatic make_line(ref logic [7:0] line[$], ref int counted);
		int n_tok;
		line.delete();
		n_tok = $urandom_range(1, 8);
		repeat (n_tok) begin
			add_token(line);
			if ($urandom_range(0, 9) < 6) add_separator(line);
		end
		counted += line.size();
	endtask

	// Receiver: stall patterns per segment, plus one long hold-off to back up the block
	initial begin : receiver
		int seg_len;
		int seg_mode;
		bit held;
		held = 0;
		wait (arst_n === 1'b1);
		forever begin
			if (!held && accepted_inputs >= 150) begin
				held = 1;
				m_tready <= 1'b0;
				repeat (400) @(posedge clk);
			end
			seg_len  = $urandom_range(20, 200);
			seg_mode = $urandom_range(0, 3);
			for (int i = 0; i < seg_len; i++) begin
				if (!held && accepted_inputs >= 150) break;
				case (seg_mode)
					0:       m_tready <= 1'b1;
					1:       m_tready <= 1'($urandom_range(0, 1));
					2:       m_tready <= ((i % 4) != 3);
					default: m_tready <= ($urandom_range(0, 4) == 0);
				endcase
				@(posedge clk);
			end
		end
	end

	// Stimulus and end of run
	initial begin : stimulus
		logic [7:0] line[$];
		int counted;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: IF mode with '<=', mode kept into next line, LET with assignment
		// and an empty string closed by end of line, parens and '<>', extreme bytes
		send_str("IF A<=B");
		send_str("=");
		send_str("LET X=\"");
		send_str("( <> )");
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b1);

		counted = 0;
		while (counted < 360) begin
			make_line(line, counted);
			send_line(line);
		end
		s_tvalid <= 1'b0;

		while (sb.beats_due.size() != 0) @(posedge clk);
		repeat (64) @(posedge clk);
		if (sb.errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/klex_pkg.sv
hw/rtl/klex_queue.sv
hw/rtl/klex_front.sv
hw/rtl/klex_back.sv
hw/rtl/keyword_operator_lexer.sv
tb/sv/keyword_operator_lexer_test.sv
